FILE: design/bqp_pkg.sv
package bqp_pkg;

  // Widths of the data path
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int STATE_W  = 48;
  localparam int ACC_W    = STATE_W + 2;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int REG_IDX_W = 3;

  // Register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_B1     = 3'd1,
    REG_B2     = 3'd2,
    REG_A1     = 3'd3,
    REG_A2     = 3'd4,
    REG_EQ_IN  = 3'd5,
    REG_ACTIVE = 3'd6
  } reg_idx_t;

  // Sequencer states: multiplies issued in M0 to M4, last product taken in M5
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]            channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_word_t;

  // Saturate an accumulator to a state word
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[ACC_W-1:STATE_W-1] == '0 || v[ACC_W-1:STATE_W-1] == '1) begin
      r = v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 37-bit value to the 32-bit feedback operand
  function automatic logic signed [COEF_W-1:0] sat_fb(input logic signed [36:0] v);
    logic signed [COEF_W-1:0] r;
    if (v[36:COEF_W-1] == '0 || v[36:COEF_W-1] == '1) begin
      r = v[COEF_W-1:0];
    end else if (v[36]) begin
      r = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 29-bit value to an output sample
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [28:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[28:SAMPLE_W-1] == '0 || v[28:SAMPLE_W-1] == '1) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[28]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: design/bqp_mul.sv
// Shared signed 32x32 multiplier with a registered product
module bqp_mul import bqp_pkg::*; (
  input  logic                     clk,
  input  logic signed [COEF_W-1:0] op_a,
  input  logic signed [COEF_W-1:0] op_b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: design/biquad_peaking_filter.sv
// Channel  Signals                     Payload
// -------  --------------------------  -------------------------------
// in       in_valid / in_stall         in_word  (channel, sample_in)
// out      out_valid / out_stall       out_word (channel_out, sample_out)
// config   cfg_wr_en                   cfg_index, cfg_data
//
// A filtered sample passes through accept, five multiplies through the one
// shared 32x32 multiplier (one per cycle, each accumulated in the cycle after),
// and a finish state that writes the state and the output register.
// A bypassed sample (filter_active low) goes from accept straight to finish.
// Synchronous reset loads the configuration defaults and clears the per-channel state, the sequencer and out_valid.
// in_stall is high during reset and while a sample is in work; the finish
// cycle waits while a previous output word is still stalled.
module biquad_peaking_filter import bqp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_wr_en,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_data
);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                     eq_in, filter_active;

  // Per-channel state
  logic signed [STATE_W-1:0] delay_one [CHANNELS];
  logic signed [STATE_W-1:0] delay_two [CHANNELS];

  // Work registers
  seq_state_t                 st, st_next;
  logic [CH_W-1:0]            ch;
  logic                       active;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [STATE_W-1:0]  y;
  logic signed [ACC_W-1:0]    t1, t2;

  logic signed [COEF_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   rsum8, rsum16;
  logic signed [STATE_W-1:0]  r8, r16;
  logic signed [STATE_W:0]    ysum, osum;
  logic signed [COEF_W-1:0]   yf;
  logic signed [SAMPLE_W-1:0] result;
  logic                       out_free;
  logic                       accept;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0       <= 32'sh1000_0000;
      coef_b1       <= '0;
      coef_b2       <= '0;
      coef_a1       <= '0;
      coef_a2       <= '0;
      eq_in         <= 1'b1;
      filter_active <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_B0:     coef_b0       <= cfg_data;
        REG_B1:     coef_b1       <= cfg_data;
        REG_B2:     coef_b2       <= cfg_data;
        REG_A1:     coef_a1       <= cfg_data;
        REG_A2:     coef_a2       <= cfg_data;
        REG_EQ_IN:  eq_in         <= cfg_data[0];
        REG_ACTIVE: filter_active <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Rounded products: Q.28 -> Q.20 and Q.36 -> Q.20
  assign rsum8  = prod + 64'sd128;
  assign rsum16 = prod + 64'sd32768;
  assign r8     = rsum8[STATE_W+7:8];
  assign r16    = rsum16[STATE_W+15:16];

  // Feedback operand and output sample from y
  assign ysum   = {y[STATE_W-1], y} + 49'sd2048;
  assign yf     = sat_fb($signed(ysum[STATE_W:12]));
  assign osum   = {y[STATE_W-1], y} + 49'sd524288;
  assign result = (active && eq_in) ? sat_sample($signed(osum[STATE_W:20])) : x;

  bqp_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Sequencer: next state and multiplier operands
  always_comb begin
    st_next  = st;
    in_stall = rst || (st != ST_IDLE);
    op_a     = coef_b0;
    op_b     = COEF_W'(x);
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          st_next = filter_active ? ST_M0 : ST_FIN;
        end
      end
      ST_M0: begin
        st_next = ST_M1;
      end
      ST_M1: begin
        op_a    = coef_b1;
        st_next = ST_M2;
      end
      ST_M2: begin
        op_a    = coef_b2;
        st_next = ST_M3;
      end
      ST_M3: begin
        op_a    = coef_a1;
        op_b    = yf;
        st_next = ST_M4;
      end
      ST_M4: begin
        op_a    = coef_a2;
        op_b    = yf;
        st_next = ST_M5;
      end
      ST_M5: begin
        st_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Input capture and accumulation, one product per cycle
  always_ff @(posedge clk) begin
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          ch     <= in_word.channel;
          x      <= in_word.sample_in;
          active <= filter_active;
        end
      end
      ST_M1: y  <= sat_state(ACC_W'(r8) + ACC_W'(delay_one[ch]));
      ST_M2: t1 <= ACC_W'(r8) + ACC_W'(delay_two[ch]);
      ST_M3: t2 <= ACC_W'(r8);
      ST_M4: t1 <= t1 - ACC_W'(r16);
      ST_M5: t2 <= t2 - ACC_W'(r16);
      default: ;
    endcase
  end

  // State update at the finish cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (st == ST_FIN && out_free && active) begin
      delay_one[ch] <= sat_state(t1);
      delay_two[ch] <= sat_state(t2);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_FIN && out_free) begin
      out_word.channel_out <= ch;
      out_word.sample_out  <= result;
    end
  end

endmodule
